// File: sv/aarm_pkg.sv
`timescale 1ns / 1ps
package aarm_pkg;

    // Normalized axis magnitudes lie below 2^30; the largest is at least 2^29 unless the axis is zero
    localparam int MAG_BITS     = 30;
    localparam int SQ_PROD_BITS = 2 * MAG_BITS;
    localparam int SQ_BITS      = SQ_PROD_BITS + 2;
    localparam int ROOT_BITS    = 31;
    localparam int SQRT_STEPS   = 31;

    localparam int ANGLE_BITS   = 32;
    localparam int OUT_BITS     = 32;
    localparam int N_ENTRIES    = 9;

    // CORDIC datapath: x/y carry 32 fraction bits plus growth, z holds the half angle
    localparam int CORDIC_STEPS = 31;
    localparam int CX_BITS      = 35;
    localparam int CZ_BITS      = 34;
    localparam int ATAN_BITS    = 31;
    localparam logic [CX_BITS-1:0] CORDIC_GAIN = 35'd2608131496;

    typedef struct packed {
        logic [2:0] neg;    // sign of each axis component
        logic       zero;   // axis has zero length
    } aarm_flags_t;

    typedef struct packed {
        logic signed [CX_BITS-1:0] x;
        logic signed [CX_BITS-1:0] y;
        logic signed [CZ_BITS-1:0] z;
    } aarm_cordic_t;

    // atan(2^-i) with 2^33 = one full turn
    function automatic logic [ATAN_BITS-1:0] atan_step(input int i);
        case (i)
            0:  return 31'd1073741824;
            1:  return 31'd633866812;
            2:  return 31'd334917814;
            3:  return 31'd170009512;
            4:  return 31'd85334662;
            5:  return 31'd42708930;
            6:  return 31'd21359676;
            7:  return 31'd10680490;
            8:  return 31'd5340326;
            9:  return 31'd2670174;
            10: return 31'd1335088;
            11: return 31'd667544;
            12: return 31'd333772;
            13: return 31'd166886;
            14: return 31'd83443;
            15: return 31'd41722;
            16: return 31'd20861;
            17: return 31'd10430;
            18: return 31'd5215;
            19: return 31'd2608;
            20: return 31'd1304;
            21: return 31'd652;
            22: return 31'd326;
            23: return 31'd163;
            24: return 31'd81;
            25: return 31'd41;
            26: return 31'd20;
            27: return 31'd10;
            28: return 31'd5;
            29: return 31'd3;
            30: return 31'd1;
            default: return '0;
        endcase
    endfunction

endpackage

// File: sv/aarm_norm_cell.sv
`timescale 1ns / 1ps
module aarm_norm_cell
    import aarm_pkg::*;
#(
    parameter int NW = 78,
    parameter int SH = 1
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [2:0][NW-1:0]   mag_in,
    input  aarm_flags_t          flags_in,
    output logic [2:0][NW-1:0]   mag_out,
    output aarm_flags_t          flags_out
);

    logic [2:0][NW-1:0] mag_reg;
    aarm_flags_t        flags_reg;
    logic [NW-1:0]      any_bits;
    logic               top_clear;

    // msb of the OR equals msb of the largest component
    assign any_bits  = mag_in[0] | mag_in[1] | mag_in[2];
    assign top_clear = (any_bits[NW-1 -: SH] == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= top_clear ? (mag_in[i] << SH) : mag_in[i];
            end
            flags_reg <= flags_in;
        end
    end

    assign mag_out   = mag_reg;
    assign flags_out = flags_reg;

endmodule

// File: sv/aarm_sqrt_cell.sv
`timescale 1ns / 1ps
module aarm_sqrt_cell
    import aarm_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [SQ_BITS-1:0]         rem_in,
    input  logic [SQ_BITS-1:0]         root_in,
    input  logic [2:0][MAG_BITS-1:0]   mag_in,
    input  aarm_flags_t                flags_in,
    output logic [SQ_BITS-1:0]         rem_out,
    output logic [SQ_BITS-1:0]         root_out,
    output logic [2:0][MAG_BITS-1:0]   mag_out,
    output aarm_flags_t                flags_out
);

    localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (2 * K);

    logic [SQ_BITS-1:0]       rem_reg;
    logic [SQ_BITS-1:0]       root_reg;
    logic [2:0][MAG_BITS-1:0] mag_reg;
    aarm_flags_t              flags_reg;
    logic [SQ_BITS:0]         trial;
    logic                     take;

    assign trial = {1'b0, root_in} + {1'b0, BIT};
    assign take  = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (take)
            begin
                rem_reg  <= rem_in - trial[SQ_BITS-1:0];
                root_reg <= (root_in >> 1) + BIT;
            end
            else
            begin
                rem_reg  <= rem_in;
                root_reg <= root_in >> 1;
            end
            mag_reg   <= mag_in;
            flags_reg <= flags_in;
        end
    end

    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign mag_out   = mag_reg;
    assign flags_out = flags_reg;

endmodule

// File: sv/aarm_div_cell.sv
`timescale 1ns / 1ps
module aarm_div_cell
    import aarm_pkg::*;
#(
    parameter int FRAC_BITS = 30,
    parameter int J = 0,
    localparam int NUMW = MAG_BITS + FRAC_BITS + 1,
    localparam int QW = FRAC_BITS + 1
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [2:0][NUMW-1:0]   rem_in,
    input  logic [2:0][QW-1:0]     quo_in,
    input  logic [ROOT_BITS-1:0]   den_in,
    input  aarm_flags_t            flags_in,
    output logic [2:0][NUMW-1:0]   rem_out,
    output logic [2:0][QW-1:0]     quo_out,
    output logic [ROOT_BITS-1:0]   den_out,
    output aarm_flags_t            flags_out
);

    logic [2:0][NUMW-1:0] rem_reg;
    logic [2:0][QW-1:0]   quo_reg;
    logic [ROOT_BITS-1:0] den_reg;
    aarm_flags_t          flags_reg;
    logic [NUMW-1:0]      dsh;

    assign dsh = NUMW'(den_in) << J;

    // restoring step, three lanes share the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= dsh)
                begin
                    rem_reg[i] <= rem_in[i] - dsh;
                    quo_reg[i] <= quo_in[i] | (QW'(1) << J);
                end
                else
                begin
                    rem_reg[i] <= rem_in[i];
                    quo_reg[i] <= quo_in[i];
                end
            end
            den_reg   <= den_in;
            flags_reg <= flags_in;
        end
    end

    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign den_out   = den_reg;
    assign flags_out = flags_reg;

endmodule

// File: sv/aarm_cordic_cell.sv
`timescale 1ns / 1ps
module aarm_cordic_cell
    import aarm_pkg::*;
#(
    parameter int I = 0
)
(
    input  logic          clk,
    input  logic          en,
    input  aarm_cordic_t  rot_in,
    output aarm_cordic_t  rot_out
);

    localparam logic signed [CZ_BITS-1:0] ANG =
        $signed({{(CZ_BITS-ATAN_BITS){1'b0}}, atan_step(I)});

    aarm_cordic_t              rot_reg;
    logic signed [CX_BITS-1:0] dx;
    logic signed [CX_BITS-1:0] dy;

    assign dx = rot_in.y >>> I;
    assign dy = rot_in.x >>> I;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!rot_in.z[CZ_BITS-1])
            begin
                rot_reg.x <= rot_in.x - dx;
                rot_reg.y <= rot_in.y + dy;
                rot_reg.z <= rot_in.z - ANG;
            end
            else
            begin
                rot_reg.x <= rot_in.x + dx;
                rot_reg.y <= rot_in.y - dy;
                rot_reg.z <= rot_in.z + ANG;
            end
        end
    end

    assign rot_out = rot_reg;

endmodule

// File: sv/axis_angle_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   a_x a_y a_z b_x b_y b_z angle, zero pad     command
// m_axis    out  r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2  axis_zero
//
// One transfer in and one out per cycle, sustained while m_axis_tready stays high.
// The axis chain sets the latency: normalize shifter cells, 31 square-root cells,
// FRAC_BITS+1 divider cells; the 31 CORDIC cells run beside it and their result
// is delayed to line up with the divider output.
// A stalled output holds every stage at once; s_axis_tready follows m_axis_tready
// while the last stage is full. Reset clears only the valid line.
module axis_angle_rotation_matrix_unit
    import aarm_pkg::*;
#(
    parameter int VEC_WIDTH = 24,
    parameter int FRAC_BITS = 30,
    localparam int IN_BITS  = 6 * VEC_WIDTH + ANGLE_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W    = N_ENTRIES * OUT_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, angle
    input  logic             s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2
    output logic             m_axis_tuser    // axis_zero
);

    localparam int VW         = VEC_WIDTH;
    localparam int PW1        = 2 * VEC_WIDTH;        // cross product term
    localparam int NW         = PW1 + MAG_BITS;       // padded magnitude for normalizing
    localparam int NORM_STEPS = $clog2(NW);
    localparam int NUMW       = MAG_BITS + FRAC_BITS + 1;
    localparam int QW         = FRAC_BITS + 1;
    localparam int EW         = FRAC_BITS + 2;        // Euler parameter, holds +-1.0
    localparam int PW         = 2 * EW;
    localparam int SW         = PW + 2;
    localparam int CS_DELAY   = 5 + NORM_STEPS + FRAC_BITS;
    localparam int NSTG       = 42 + NORM_STEPS + FRAC_BITS;

    localparam logic signed [CX_BITS:0] CS_HALF =
        {{(CX_BITS-30){1'b0}}, 1'b1, {(31-FRAC_BITS){1'b0}}};
    localparam logic signed [CX_BITS:0] CS_ONE =
        {{(CX_BITS-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [PW:0] E_HALF =
        {{(PW+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [SW:0] DIAG_HALF =
        {{(SW+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [SW:0] OFF_HALF =
        {{(SW+2-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-2){1'b0}}};
    localparam logic signed [SW:0] OUT_ONE =
        {{(SW-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [OUT_BITS-1:0] UNIT_WORD = OUT_BITS'(1) << FRAC_BITS;

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] vld_reg;
    logic            adv;

    assign adv           = m_axis_tready || !vld_reg[NSTG-1];
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], s_axis_tvalid};
        end
    end

    // ---------------- input fields ----------------
    logic signed [VW-1:0]         in_a [3];
    logic signed [VW-1:0]         in_b [3];
    logic signed [ANGLE_BITS-1:0] in_angle;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_a[i] = s_axis_tdata[i*VW +: VW];
            in_b[i] = s_axis_tdata[(i+3)*VW +: VW];
        end
        in_angle = s_axis_tdata[6*VW +: ANGLE_BITS];
    end

    // ---------------- stage 1: cross product terms ----------------
    logic signed [PW1-1:0] xa_reg, xb_reg, ya_reg, yb_reg, za_reg, zb_reg;
    logic signed [VW-1:0]  a_reg [3];
    logic                  cmd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xa_reg <= PW1'(in_a[1]) * PW1'(in_b[2]);
            xb_reg <= PW1'(in_a[2]) * PW1'(in_b[1]);
            ya_reg <= PW1'(in_a[2]) * PW1'(in_b[0]);
            yb_reg <= PW1'(in_a[0]) * PW1'(in_b[2]);
            za_reg <= PW1'(in_a[0]) * PW1'(in_b[1]);
            zb_reg <= PW1'(in_a[1]) * PW1'(in_b[0]);
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= in_a[i];
            end
            cmd_reg <= s_axis_tuser;
        end
    end

    // ---------------- stage 2: axis select, magnitude, sign ----------------
    logic signed [PW1:0] v_next [3];
    logic        [PW1:0] vmag_next [3];
    logic [2:0][NW-1:0]  mag_next;
    aarm_flags_t         flags_next;
    logic [2:0][NW-1:0]  mag_reg;
    aarm_flags_t         flags_reg;

    always_comb
    begin
        if (cmd_reg)
        begin
            v_next[0] = $signed({xa_reg[PW1-1], xa_reg}) - $signed({xb_reg[PW1-1], xb_reg});
            v_next[1] = $signed({ya_reg[PW1-1], ya_reg}) - $signed({yb_reg[PW1-1], yb_reg});
            v_next[2] = $signed({za_reg[PW1-1], za_reg}) - $signed({zb_reg[PW1-1], zb_reg});
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                v_next[i] = $signed({{(PW1+1-VW){a_reg[i][VW-1]}}, a_reg[i]});
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            vmag_next[i]      = v_next[i][PW1] ? -v_next[i] : v_next[i];
            mag_next[i]       = {vmag_next[i][PW1-1:0], {MAG_BITS{1'b0}}};
            flags_next.neg[i] = v_next[i][PW1];
        end
        flags_next.zero = (v_next[0] == '0) && (v_next[1] == '0) && (v_next[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg   <= mag_next;
            flags_reg <= flags_next;
        end
    end

    // ---------------- normalizing shifter cells ----------------
    logic [2:0][NW-1:0] norm_mag   [NORM_STEPS+1];
    aarm_flags_t        norm_flags [NORM_STEPS+1];

    assign norm_mag[0]   = mag_reg;
    assign norm_flags[0] = flags_reg;

    for (genvar k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        aarm_norm_cell #(
            .NW (NW),
            .SH (1 << (NORM_STEPS - 1 - k))
        ) u_cell (
            .clk       (clk),
            .en        (adv),
            .mag_in    (norm_mag[k]),
            .flags_in  (norm_flags[k]),
            .mag_out   (norm_mag[k+1]),
            .flags_out (norm_flags[k+1])
        );
    end

    // ---------------- squares, then their sum ----------------
    logic [2:0][MAG_BITS-1:0]     nm;
    logic [2:0][MAG_BITS-1:0]     sqm_reg;
    logic [2:0][SQ_PROD_BITS-1:0] sq_reg;
    aarm_flags_t                  sqf_reg;
    logic [2:0][MAG_BITS-1:0]     sum_m_reg;
    logic [SQ_BITS-1:0]           sum_reg;
    aarm_flags_t                  sumf_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nm[i] = norm_mag[NORM_STEPS][i][NW-1 -: MAG_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SQ_PROD_BITS'(nm[i]) * SQ_PROD_BITS'(nm[i]);
            end
            sqm_reg   <= nm;
            sqf_reg   <= norm_flags[NORM_STEPS];
            sum_reg   <= SQ_BITS'(sq_reg[0]) + SQ_BITS'(sq_reg[1]) + SQ_BITS'(sq_reg[2]);
            sum_m_reg <= sqm_reg;
            sumf_reg  <= sqf_reg;
        end
    end

    // ---------------- square root cells ----------------
    logic [SQ_BITS-1:0]       sq_rem  [SQRT_STEPS+1];
    logic [SQ_BITS-1:0]       sq_root [SQRT_STEPS+1];
    logic [2:0][MAG_BITS-1:0] sq_mag  [SQRT_STEPS+1];
    aarm_flags_t              sq_flg  [SQRT_STEPS+1];

    assign sq_rem[0]  = sum_reg;
    assign sq_root[0] = '0;
    assign sq_mag[0]  = sum_m_reg;
    assign sq_flg[0]  = sumf_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        aarm_sqrt_cell #(
            .K (SQRT_STEPS - 1 - k)
        ) u_cell (
            .clk       (clk),
            .en        (adv),
            .rem_in    (sq_rem[k]),
            .root_in   (sq_root[k]),
            .mag_in    (sq_mag[k]),
            .flags_in  (sq_flg[k]),
            .rem_out   (sq_rem[k+1]),
            .root_out  (sq_root[k+1]),
            .mag_out   (sq_mag[k+1]),
            .flags_out (sq_flg[k+1])
        );
    end

    // ---------------- dividend with rounding term ----------------
    logic [ROOT_BITS-1:0]  len;
    logic [2:0][NUMW-1:0]  num_reg;
    logic [ROOT_BITS-1:0]  den_reg;
    aarm_flags_t           numf_reg;

    assign len = sq_root[SQRT_STEPS][ROOT_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= NUMW'({sq_mag[SQRT_STEPS][i], {FRAC_BITS{1'b0}}})
                              + NUMW'(len >> 1);
            end
            den_reg  <= len;
            numf_reg <= sq_flg[SQRT_STEPS];
        end
    end

    // ---------------- divider cells ----------------
    logic [2:0][NUMW-1:0]  dv_rem [QW+1];
    logic [2:0][QW-1:0]    dv_quo [QW+1];
    logic [ROOT_BITS-1:0]  dv_den [QW+1];
    aarm_flags_t           dv_flg [QW+1];

    assign dv_rem[0] = num_reg;
    assign dv_quo[0] = '0;
    assign dv_den[0] = den_reg;
    assign dv_flg[0] = numf_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        aarm_div_cell #(
            .FRAC_BITS (FRAC_BITS),
            .J         (FRAC_BITS - k)
        ) u_cell (
            .clk       (clk),
            .en        (adv),
            .rem_in    (dv_rem[k]),
            .quo_in    (dv_quo[k]),
            .den_in    (dv_den[k]),
            .flags_in  (dv_flg[k]),
            .rem_out   (dv_rem[k+1]),
            .quo_out   (dv_quo[k+1]),
            .den_out   (dv_den[k+1]),
            .flags_out (dv_flg[k+1])
        );
    end

    // ---------------- CORDIC cells on the half angle ----------------
    aarm_cordic_t rot [CORDIC_STEPS+1];

    always_comb
    begin
        rot[0].x = $signed(CORDIC_GAIN);
        rot[0].y = '0;
        rot[0].z = $signed({{(CZ_BITS-ANGLE_BITS){in_angle[ANGLE_BITS-1]}}, in_angle});
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        aarm_cordic_cell #(
            .I (k)
        ) u_cell (
            .clk     (clk),
            .en      (adv),
            .rot_in  (rot[k]),
            .rot_out (rot[k+1])
        );
    end

    function automatic logic signed [EW-1:0] round_cs(input logic signed [CX_BITS-1:0] v);
        logic signed [CX_BITS:0] t;
        logic signed [CX_BITS:0] h;
        t = $signed({v[CX_BITS-1], v}) + CS_HALF;
        h = t >>> (32 - FRAC_BITS);
        if (h > CS_ONE)
        begin
            return EW'(CS_ONE);
        end
        if (h < -CS_ONE)
        begin
            return EW'(-CS_ONE);
        end
        return EW'(h);
    endfunction

    logic signed [EW-1:0] cd_reg [CS_DELAY+1];
    logic signed [EW-1:0] sd_reg [CS_DELAY+1];

    // cd_reg[0] is the rounding stage, the rest line up with the divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cd_reg[0] <= round_cs(rot[CORDIC_STEPS].x);
            sd_reg[0] <= round_cs(rot[CORDIC_STEPS].y);
            for (int i = 1; i <= CS_DELAY; i++)
            begin
                cd_reg[i] <= cd_reg[i-1];
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // ---------------- Euler parameters ----------------
    logic signed [EW-1:0] u [3];
    logic signed [PW-1:0] pu_reg [3];
    logic signed [EW-1:0] ca_reg;
    logic                 za_reg_f;
    logic signed [EW-1:0] e_reg [4];
    logic                 zb_reg_f;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u[i] = dv_flg[QW].neg[i] ? -$signed(EW'(dv_quo[QW][i])) : $signed(EW'(dv_quo[QW][i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pu_reg[i]  <= PW'(u[i]) * PW'(sd_reg[CS_DELAY]);
                e_reg[i+1] <= EW'(($signed({pu_reg[i][PW-1], pu_reg[i]}) + E_HALF) >>> FRAC_BITS);
            end
            ca_reg   <= cd_reg[CS_DELAY];
            za_reg_f <= dv_flg[QW].zero;
            e_reg[0] <= ca_reg;
            zb_reg_f <= za_reg_f;
        end
    end

    // ---------------- parameter products ----------------
    logic signed [PW-1:0] p00_reg, p11_reg, p22_reg, p33_reg;
    logic signed [PW-1:0] p01_reg, p02_reg, p03_reg, p12_reg, p13_reg, p23_reg;
    logic                 zc_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg <= PW'(e_reg[0]) * PW'(e_reg[0]);
            p11_reg <= PW'(e_reg[1]) * PW'(e_reg[1]);
            p22_reg <= PW'(e_reg[2]) * PW'(e_reg[2]);
            p33_reg <= PW'(e_reg[3]) * PW'(e_reg[3]);
            p01_reg <= PW'(e_reg[0]) * PW'(e_reg[1]);
            p02_reg <= PW'(e_reg[0]) * PW'(e_reg[2]);
            p03_reg <= PW'(e_reg[0]) * PW'(e_reg[3]);
            p12_reg <= PW'(e_reg[1]) * PW'(e_reg[2]);
            p13_reg <= PW'(e_reg[1]) * PW'(e_reg[3]);
            p23_reg <= PW'(e_reg[2]) * PW'(e_reg[3]);
            zc_reg  <= zb_reg_f;
        end
    end

    // ---------------- matrix sums ----------------
    function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
        return $signed({{2{p[PW-1]}}, p});
    endfunction

    logic signed [SW-1:0] sum_e_reg [N_ENTRIES];
    logic                 zd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_e_reg[0] <= ext(p00_reg) + ext(p11_reg) - ext(p22_reg) - ext(p33_reg);
            sum_e_reg[1] <= ext(p12_reg) - ext(p03_reg);
            sum_e_reg[2] <= ext(p13_reg) + ext(p02_reg);
            sum_e_reg[3] <= ext(p12_reg) + ext(p03_reg);
            sum_e_reg[4] <= ext(p00_reg) - ext(p11_reg) + ext(p22_reg) - ext(p33_reg);
            sum_e_reg[5] <= ext(p23_reg) - ext(p01_reg);
            sum_e_reg[6] <= ext(p13_reg) - ext(p02_reg);
            sum_e_reg[7] <= ext(p23_reg) + ext(p01_reg);
            sum_e_reg[8] <= ext(p00_reg) - ext(p11_reg) - ext(p22_reg) + ext(p33_reg);
            zd_reg       <= zc_reg;
        end
    end

    // ---------------- rounding, saturation, output register ----------------
    function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [SW:0] v);
        if (v > OUT_ONE)
        begin
            return OUT_BITS'(OUT_ONE);
        end
        if (v < -OUT_ONE)
        begin
            return OUT_BITS'(-OUT_ONE);
        end
        return OUT_BITS'(v);
    endfunction

    logic signed [SW:0]                    rnd [N_ENTRIES];
    logic [N_ENTRIES-1:0][OUT_BITS-1:0]    out_reg;
    logic                                  zero_out_reg;

    always_comb
    begin
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            if (i == 0 || i == 4 || i == 8)
            begin
                rnd[i] = ($signed({sum_e_reg[i][SW-1], sum_e_reg[i]}) + DIAG_HALF) >>> FRAC_BITS;
            end
            else
            begin
                // off-diagonal entries carry the factor of two
                rnd[i] = ($signed({sum_e_reg[i][SW-1], sum_e_reg[i]}) + OFF_HALF)
                         >>> (FRAC_BITS - 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N_ENTRIES; i++)
            begin
                if (zd_reg)
                begin
                    out_reg[i] <= (i == 0 || i == 4 || i == 8) ? UNIT_WORD : '0;
                end
                else
                begin
                    out_reg[i] <= sat_out(rnd[i]);
                end
            end
            zero_out_reg <= zd_reg;
        end
    end

    assign m_axis_tdata = out_reg;
    assign m_axis_tuser = zero_out_reg;

    // ---------------- assertions ----------------
    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[OUT_BITS-1:0] == UNIT_WORD &&
            m_axis_tdata[2*OUT_BITS-1:OUT_BITS] == '0 &&
            m_axis_tdata[5*OUT_BITS-1:4*OUT_BITS] == UNIT_WORD)
        else $error("zero axis did not give identity");

    a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[OUT_BITS-1:0]) <= $signed(UNIT_WORD) &&
            $signed(m_axis_tdata[OUT_BITS-1:0]) >= -$signed(UNIT_WORD))
        else $error("matrix entry out of unit range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted transfer not entered in pipeline");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |=> $stable(vld_reg) && $stable(out_reg))
        else $error("pipeline moved during stall");

endmodule
